@@ rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package u8u16_pkg;

  // Reason a conversion ended, reported on its final beat.
  typedef enum logic [1:0] {
    CauseRun  = 2'd0,
    CauseEnd  = 2'd1,
    CauseNul  = 2'd2,
    CauseFull = 2'd3
  } cause_e;

  localparam logic [15:0] ReplUnit = 16'hFFFD;

  // One result beat.
  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    logic        done;
    cause_e      cause;
    logic [31:0] units;
    logic [31:0] bytes;
  } res_t;

  // Results of one byte, handed to the result queue.
  typedef struct packed {
    res_t [1:0] item;
    logic [1:0] num;
  } push_t;

  // Result queue status.
  typedef struct packed {
    logic valid;
    logic room;
  } qstat_t;

  // Conversion state carried from byte to byte.
  typedef struct packed {
    logic [20:0] point;
    logic [2:0]  seq_len;
    logic [1:0]  left;
    logic [31:0] units;
    logic [31:0] bytes;
    logic        stopped;
  } conv_t;

endpackage

@@ rtl/u8u16_step.sv @@
// Per-byte decode step: next conversion state and up to two result beats.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_step (
  input  u8u16_pkg::conv_t cur_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic [31:0]      cap_i,
  output u8u16_pkg::conv_t nxt_o,
  output u8u16_pkg::push_t push_o
);

  function automatic logic point_ok(input logic [20:0] cp, input logic [2:0] len);
    logic ok;
    ok = 1'b0;
    case (len)
      3'd2:    ok = (cp >= 21'h80);
      3'd3:    ok = (cp >= 21'h800) && ((cp < 21'hD800) || (cp > 21'hDFFF));
      3'd4:    ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  always_comb begin
    u8u16_pkg::res_t   slot [3];
    logic [1:0]        k;
    logic              idx;
    u8u16_pkg::cause_e cause;
    logic              as_lead;
    logic [20:0]       pp;
    logic [2:0]        sl;
    logic [1:0]        bl;
    logic [31:0]       uc;
    logic [31:0]       bc;
    logic [20:0]       cp;
    logic [20:0]       off;

    for (int i = 0; i < 3; i++) begin
      slot[i] = '0;
    end
    k       = 2'd0;
    idx     = 1'b0;
    cause   = u8u16_pkg::CauseRun;
    as_lead = 1'b1;
    pp      = cur_i.point;
    sl      = cur_i.seq_len;
    bl      = cur_i.left;
    uc      = cur_i.units;
    bc      = cur_i.bytes;
    cp      = '0;
    off     = '0;
    nxt_o   = cur_i;

    if (cur_i.stopped) begin
      // Swallow bytes until the end of the source, then start afresh.
      if (in_last_i) begin
        nxt_o = '0;
      end
    end else begin
      if (bl != 2'd0) begin
        if (in_byte_i[7:6] == 2'b10) begin
          as_lead = 1'b0;
          if (bc != '1) bc = bc + 32'd1;
          pp = {pp[14:0], in_byte_i[5:0]};
          bl = bl - 2'd1;
          if (bl == 2'd0) begin
            cp = point_ok(pp, sl) ? pp : {5'd0, u8u16_pkg::ReplUnit};
            pp = '0;
            sl = '0;
            if (cp < 21'h10000) begin
              slot[k].unit  = cp[15:0];
              slot[k].valid = 1'b1;
              k  = k + 2'd1;
              uc = uc + 32'd1;
            end else if (({1'b0, uc} + 33'd2) > {1'b0, cap_i}) begin
              cause = u8u16_pkg::CauseFull;
            end else begin
              off = cp - 21'h10000;
              slot[k].unit  = 16'hD800 + {6'd0, off[19:10]};
              slot[k].valid = 1'b1;
              k = k + 2'd1;
              slot[k].unit  = 16'hDC00 + {6'd0, off[9:0]};
              slot[k].valid = 1'b1;
              k  = k + 2'd1;
              uc = uc + 32'd2;
            end
          end
        end else begin
          // Broken sequence: replacement, then the byte starts anew unless the output is full.
          slot[k].unit  = u8u16_pkg::ReplUnit;
          slot[k].valid = 1'b1;
          k  = k + 2'd1;
          uc = uc + 32'd1;
          pp = '0;
          sl = '0;
          bl = '0;
          if (uc >= cap_i) begin
            cause   = u8u16_pkg::CauseFull;
            as_lead = 1'b0;
          end
        end
      end

      if (as_lead && (cause == u8u16_pkg::CauseRun)) begin
        if (uc >= cap_i) begin
          cause = u8u16_pkg::CauseFull;
        end else begin
          if (bc != '1) bc = bc + 32'd1;
          if (!in_byte_i[7]) begin
            slot[k].unit  = {8'd0, in_byte_i};
            slot[k].valid = 1'b1;
            k = k + 2'd1;
            if (in_byte_i == 8'd0) begin
              cause = u8u16_pkg::CauseNul;
            end else begin
              uc = uc + 32'd1;
            end
          end else if (in_byte_i inside {[8'hC2:8'hDF]}) begin
            pp = {16'd0, in_byte_i[4:0]};
            sl = 3'd2;
            bl = 2'd1;
          end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
            pp = {17'd0, in_byte_i[3:0]};
            sl = 3'd3;
            bl = 2'd2;
          end else if (in_byte_i inside {[8'hF0:8'hF4]}) begin
            pp = {18'd0, in_byte_i[2:0]};
            sl = 3'd4;
            bl = 2'd3;
          end else begin
            slot[k].unit  = u8u16_pkg::ReplUnit;
            slot[k].valid = 1'b1;
            k  = k + 2'd1;
            uc = uc + 32'd1;
          end
        end
      end

      if ((cause == u8u16_pkg::CauseRun) && in_last_i) begin
        if (bl != 2'd0) begin
          slot[k].unit  = u8u16_pkg::ReplUnit;
          slot[k].valid = 1'b1;
          k  = k + 2'd1;
          uc = uc + 32'd1;
          pp = '0;
          sl = '0;
          bl = '0;
        end
        cause = u8u16_pkg::CauseEnd;
      end

      if ((cause == u8u16_pkg::CauseRun) && (uc >= cap_i)) begin
        cause = u8u16_pkg::CauseFull;
      end

      nxt_o.point   = pp;
      nxt_o.seq_len = sl;
      nxt_o.left    = bl;
      nxt_o.units   = uc;
      nxt_o.bytes   = bc;

      if (cause != u8u16_pkg::CauseRun) begin
        // An empty status beat carries the stop when nothing was written.
        if (k == 2'd0) begin
          k = 2'd1;
        end
        idx = (k != 2'd1);
        slot[idx].done  = 1'b1;
        slot[idx].cause = cause;
        slot[idx].units = uc;
        slot[idx].bytes = (cause == u8u16_pkg::CauseNul) ? 32'd0 : bc;
        if (in_last_i) begin
          nxt_o = '0;
        end else begin
          nxt_o.stopped = 1'b1;
        end
      end
    end

    push_o.item[0] = slot[0];
    push_o.item[1] = slot[1];
    push_o.num     = (k >= 2'd2) ? 2'd2 : k;
  end

endmodule

@@ rtl/u8u16_resq.sv @@
// Three-entry result queue: takes up to two beats a cycle, sends one.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8u16_pkg::push_t   push_i,
  input  logic               pop_i,
  output u8u16_pkg::res_t    head_o,
  output u8u16_pkg::qstat_t  stat_o
);

  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             base;
  u8u16_pkg::res_t [2:0]  ent_q, ent_d;

  always_comb begin
    base  = cnt_q - {1'b0, pop_i};
    ent_d = ent_q;
    if (pop_i) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
    if (push_i.num != 2'd0) begin
      ent_d[base] = push_i.item[0];
    end
    if ((push_i.num == 2'd2) && (base != 2'd2)) begin
      ent_d[base + 2'd1] = push_i.item[1];
    end
    cnt_d = base + push_i.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o       = ent_q[0];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.room  = (base <= 2'd1);

endmodule

@@ rtl/utf8_to_utf16_converter.sv @@
// Top level of the UTF-8 to UTF-16 converter: byte register, decode step,
// result queue and the configuration register. Depends on u8u16_pkg,
// u8u16_step and u8u16_resq.
//
// Usage. UTF-8 bytes arrive one per beat on the s_axis channel, tlast
// marking the final byte of a source. UTF-16 units leave on m_axis, one per
// beat; the final beat of a conversion carries tlast together with the stop
// cause and the unit and byte counts. A code point above U+FFFF gives two
// beats, so one byte can produce up to two beats. The unit capacity is set
// through the APB-style port at address 0 while the block is idle.
// An accepted byte waits in the byte register; the decode step then writes its
// beats into the result queue, whose head drives m_axis.
// Throughput is one byte per cycle while the receiver takes one beat per
// cycle; it is bounded by the single m_axis beat sent per cycle.
// When the receiver stalls, the three-entry result queue keeps filling until
// it cannot hold the worst case of two more beats, then the byte register
// holds and s_axis_tready falls. Reset clears the capacity to zero, empties
// the queue and clears the conversion state.
`timescale 1ns / 1ps

module utf8_to_utf16_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // Output unit stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] out_unit, [47:16] units_written,
                                      // [79:48] bytes_consumed
  output logic [2:0]  m_axis_tuser,   // [0] unit_valid, [2:1] stop_cause
  output logic        m_axis_tlast,   // done_res
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Word index of the capacity register (byte address bit 2).
  localparam logic RegCapacity = 1'b0;

  logic [31:0]       cap_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  u8u16_pkg::conv_t  st_q;
  u8u16_pkg::conv_t  st_nxt;
  u8u16_pkg::push_t  step_res;
  u8u16_pkg::push_t  push;
  u8u16_pkg::res_t   head;
  u8u16_pkg::qstat_t qstat;
  logic              fire;
  logic              in_acc;
  logic              out_acc;
  logic              cfg_wr;

  // The decode step fires when a byte waits and the queue can take its beats.
  assign fire    = in_vld_q && qstat.room;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = !in_vld_q || fire;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegCapacity);
  assign prdata = (paddr[2] == RegCapacity) ? cap_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= '0;
      in_vld_q <= 1'b0;
      st_q     <= '0;
    end else begin
      if (cfg_wr) begin
        cap_q <= pwdata;
      end
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        st_q <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  u8u16_step u_step (
    .cur_i     (st_q),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .cap_i     (cap_q),
    .nxt_o     (st_nxt),
    .push_o    (step_res)
  );

  always_comb begin
    push = step_res;
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  u8u16_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_acc),
    .head_o (head),
    .stat_o (qstat)
  );

  assign m_axis_tvalid = qstat.valid;
  assign m_axis_tdata  = {head.bytes, head.units, head.unit};
  assign m_axis_tuser  = {head.cause, head.valid};
  assign m_axis_tlast  = head.done;

  // A stopped conversion only discards bytes.
  a_stopped_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && st_q.stopped) |-> (step_res.num == 2'd0))
    else $error("stopped conversion produced a result");

  // Beats before the final one carry no status.
  a_mid_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |->
      ((m_axis_tuser[2:1] == u8u16_pkg::CauseRun) && (m_axis_tdata[79:16] == 64'd0)))
    else $error("status on a beat that is not final");

  // The final beat always names a stop cause.
  a_done_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:1] != u8u16_pkg::CauseRun))
    else $error("final beat without a stop cause");

  // A stop on NUL reports no byte count.
  a_nul_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:1] == u8u16_pkg::CauseNul)) |->
      (m_axis_tdata[79:48] == 32'd0))
    else $error("byte count reported on a NUL stop");

endmodule

@@ test/tb_utf8_to_utf16_converter.sv @@
// Self-checking testbench for utf8_to_utf16_converter: random and directed UTF-8
// byte streams under random stalls, checked beat by beat against a local decoder.
// Depends on u8u16_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_converter;

  // Register address of the unit capacity.
  localparam logic [2:0] CapacityAddr = 3'd0;
  // Cycles allowed for bytes that produce no beat to leave the pipeline.
  localparam int SettleCycles = 8;
  // Source bytes to queue in the random part.
  localparam int RandomBytes = 700;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;          // [15:0] out_unit, [47:16] units_written,
                                      // [79:48] bytes_consumed
  logic [2:0]  m_axis_tuser;          // [0] unit_valid, [2:1] stop_cause
  logic        m_axis_tlast;          // done_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = CapacityAddr;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  utf8_to_utf16_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Bytes waiting to be sent, filled by the stimulus process and drained by the driver.
  byte_beat_t       bytes_to_send[$];
  // Scratch buffer in which one source is assembled before it is queued.
  logic [7:0]       draft[$];
  // UTF-16 beats that the converter still owes us, oldest first.
  u8u16_pkg::res_t  units_due[$];

  int beats_queued = 0;
  int beats_taken = 0;
  int bytes_decoded = 0;
  int units_checked = 0;
  int mismatches = 0;
  int stops_by_cause[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Local copy of the converter's configuration and conversion state.
  logic [31:0]     unit_cap = 32'h0;
  logic [20:0]     acc_point = '0;
  logic [2:0]      acc_len = '0;
  logic [1:0]      trail_left = '0;
  logic [31:0]     unit_tally = '0;
  logic [31:0]     byte_tally = '0;
  logic            halted = 1'b0;
  u8u16_pkg::res_t step_res[2];
  int              step_n;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model. Each accepted byte is run through decode_byte, which updates
  // the local state and appends the beats that byte must produce to units_due.
  // ---------------------------------------------------------------------------

  // A conversion ends: everything but the capacity goes back to zero.
  function automatic void restart_conversion();
    acc_point  = '0;
    acc_len    = '0;
    trail_left = '0;
    unit_tally = '0;
    byte_tally = '0;
    halted     = 1'b0;
  endfunction

  // Appends one beat to this byte's results; counts are filled in later if it ends
  // the conversion.
  function automatic void add_result(input logic [15:0] unit, input logic valid);
    if (step_n < 2) begin
      step_res[step_n]       = '0;
      step_res[step_n].unit  = unit;
      step_res[step_n].valid = valid;
      step_res[step_n].cause = u8u16_pkg::CauseRun;
      step_n++;
    end
  endfunction

  // A unit that lands in the output and counts against the capacity.
  function automatic void add_unit(input logic [15:0] unit);
    add_result(unit, 1'b1);
    unit_tally++;
  endfunction

  // The byte counter sticks at its maximum rather than wrapping.
  function automatic void count_byte();
    if (byte_tally != 32'hFFFF_FFFF) byte_tally++;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [20:0]       cp;
    logic              ok;
    logic              as_lead;
    u8u16_pkg::cause_e cause;
    step_n  = 0;
    cause   = u8u16_pkg::CauseRun;
    as_lead = 1'b1;

    // After a stop every byte is dropped until the end of the source.
    if (halted) begin
      if (last) restart_conversion();
      return;
    end

    if (trail_left != 0) begin
      if (b[7:6] == 2'b10) begin
        // A continuation byte adds six bits to the code point under construction.
        as_lead = 1'b0;
        count_byte();
        acc_point = {acc_point[14:0], b[5:0]};
        trail_left--;
        if (trail_left == 0) begin
          // The sequence is complete: reject overlong forms, surrogates and
          // anything beyond U+10FFFF.
          cp = acc_point;
          case (acc_len)
            3'd2:    ok = cp >= 21'h80;
            3'd3:    ok = cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
            3'd4:    ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
            default: ok = 1'b0;
          endcase
          if (!ok) cp = {5'd0, u8u16_pkg::ReplUnit};
          acc_point = '0;
          acc_len   = '0;
          if (cp < 21'h10000) begin
            add_unit(cp[15:0]);
          end else if ({1'b0, unit_tally} + 33'd2 > {1'b0, unit_cap}) begin
            // Half a surrogate pair is never written: stop with nothing out.
            cause = u8u16_pkg::CauseFull;
          end else begin
            cp = cp - 21'h10000;
            add_unit(16'hD800 + {6'd0, cp[19:10]});
            add_unit(16'hDC00 + {6'd0, cp[9:0]});
          end
        end
      end else begin
        // A non-continuation byte breaks the sequence. It is then decoded as a
        // fresh lead, unless the replacement used up the last free unit.
        add_unit(u8u16_pkg::ReplUnit);
        acc_point  = '0;
        acc_len    = '0;
        trail_left = '0;
        if (unit_tally >= unit_cap) begin
          cause   = u8u16_pkg::CauseFull;
          as_lead = 1'b0;
        end
      end
    end

    if (as_lead && cause == u8u16_pkg::CauseRun) begin
      if (unit_tally >= unit_cap) begin
        // No room left at a lead byte: the byte is left unconsumed.
        cause = u8u16_pkg::CauseFull;
      end else begin
        count_byte();
        if (b < 8'h80) begin
          if (b == 8'h00) begin
            // NUL is written but does not count as a unit.
            add_result(16'h0000, 1'b1);
            cause = u8u16_pkg::CauseNul;
          end else begin
            add_unit({8'h00, b});
          end
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          acc_point  = {16'd0, b[4:0]};
          acc_len    = 3'd2;
          trail_left = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          acc_point  = {17'd0, b[3:0]};
          acc_len    = 3'd3;
          trail_left = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          acc_point  = {18'd0, b[2:0]};
          acc_len    = 3'd4;
          trail_left = 2'd3;
        end else begin
          // Lone continuation bytes, C0, C1 and F5 to FF.
          add_unit(u8u16_pkg::ReplUnit);
        end
      end
    end

    if (cause == u8u16_pkg::CauseRun && last) begin
      // The source ran out in the middle of a sequence.
      if (trail_left != 0) begin
        add_unit(u8u16_pkg::ReplUnit);
        acc_point  = '0;
        acc_len    = '0;
        trail_left = '0;
      end
      cause = u8u16_pkg::CauseEnd;
    end

    if (cause == u8u16_pkg::CauseRun && unit_tally >= unit_cap) cause = u8u16_pkg::CauseFull;

    if (cause != u8u16_pkg::CauseRun) begin
      // The final beat of the conversion carries the counts; a stop that wrote
      // nothing still produces one beat with unit_valid low.
      if (step_n == 0) add_result(16'h0000, 1'b0);
      step_res[step_n-1].done  = 1'b1;
      step_res[step_n-1].cause = cause;
      step_res[step_n-1].units = unit_tally;
      step_res[step_n-1].bytes = (cause == u8u16_pkg::CauseNul) ? 32'h0 : byte_tally;
      if (last) restart_conversion();
      else halted = 1'b1;
    end

    for (int i = 0; i < step_n; i++) units_due.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every failure prints one line and is counted.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s is %h, expected %h",
                                units_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. A new beat is presented only once the previous one has been
  // taken. Idle bursts are inserted at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_bytes
    byte_beat_t nxt;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (bytes_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap      <= $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = bytes_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
      end
    end
  end

  // Unit receiver: back-pressure in random bursts, drawn like the driver's idle bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap      <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Output beats are checked against the oldest expectation; accepted
  // input bytes feed the decoder model. A byte cannot produce a beat in the cycle
  // it is taken, so the two handshakes at one edge never interact.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_streams
    u8u16_pkg::res_t seen;
    u8u16_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.unit  = m_axis_tdata[15:0];
        seen.units = m_axis_tdata[47:16];
        seen.bytes = m_axis_tdata[79:48];
        seen.valid = m_axis_tuser[0];
        seen.cause = u8u16_pkg::cause_e'(m_axis_tuser[2:1]);
        seen.done  = m_axis_tlast;
        if (units_due.size() == 0) begin
          report_mismatch($sformatf("beat with unit %h arrived with nothing outstanding",
                                    seen.unit));
        end else begin
          want = units_due.pop_front();
          compare_field("out_unit", {16'd0, seen.unit}, {16'd0, want.unit});
          compare_field("unit_valid", {31'd0, seen.valid}, {31'd0, want.valid});
          compare_field("done_res", {31'd0, seen.done}, {31'd0, want.done});
          compare_field("stop_cause", {30'd0, seen.cause}, {30'd0, want.cause});
          compare_field("units_written", seen.units, want.units);
          compare_field("bytes_consumed", seen.bytes, want.bytes);
          if (want.done) stops_by_cause[want.cause]++;
        end
        units_checked++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!halted) bytes_decoded++;
        decode_byte(s_axis_tdata, s_axis_tlast);
        beats_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Moves the assembled source into the send queue; tlast marks its final byte
  // only when the source is to end here.
  function automatic void flush_draft(input logic terminate);
    byte_beat_t bt;
    foreach (draft[i]) begin
      bt.data = draft[i];
      bt.last = terminate && (i == draft.size() - 1);
      bytes_to_send.push_back(bt);
    end
    beats_queued += draft.size();
    draft.delete();
  endfunction

  // Encodes a code point in the requested number of bytes, whether or not that
  // length is the legal one, so overlong and oversized forms come out too.
  function automatic void encode_point(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        draft.push_back({3'b110, cp[10:6]});
        draft.push_back({2'b10, cp[5:0]});
      end
      3: begin
        draft.push_back({4'b1110, cp[15:12]});
        draft.push_back({2'b10, cp[11:6]});
        draft.push_back({2'b10, cp[5:0]});
      end
      default: begin
        draft.push_back({5'b11110, cp[20:18]});
        draft.push_back({2'b10, cp[17:12]});
        draft.push_back({2'b10, cp[11:6]});
        draft.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // One source of mostly well-formed text with a sprinkling of damage.
  function automatic void queue_source(input int chars, input logic terminate);
    int         pick;
    int         k;
    logic [7:0] rb;
    for (k = 0; k < chars; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        rb = ($urandom_range(0, 99) < 4) ? 8'h00 : 8'($urandom_range(1, 127));
        draft.push_back(rb);
      end else if (pick < 55) begin
        encode_point(21'($urandom_range(21'h80, 21'h7FF)), 2);
      end else if (pick < 70) begin
        encode_point(21'($urandom_range(21'h800, 21'hFFFF)), 3);
      end else if (pick < 85) begin
        encode_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      end else if (pick < 90) begin
        rb = 8'($urandom_range(0, 255));
        draft.push_back(rb);
      end else if (pick < 94) begin
        // A lead byte whose continuation never comes.
        rb = 8'($urandom_range(8'hC2, 8'hF4));
        draft.push_back(rb);
      end else if (pick < 97) begin
        encode_point(21'($urandom_range(21'h0, 21'h7FF)), 3);
      end else begin
        encode_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end
    end
    flush_draft(terminate);
  endfunction

  // Blocks until every queued byte has been taken and every beat has arrived,
  // then lets bytes without a result drain from the pipeline.
  task automatic wait_idle();
    while (beats_taken != beats_queued || units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge that
  // closes the access cycle.
  task automatic write_capacity(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapacityAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unit_cap = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int          phase;
    int          start_beats;
    logic        carry_trail;
    logic        tight;
    logic [31:0] cap;
    logic [7:0]  rb;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero capacity: the first lead byte stops the conversion unconsumed, and
    // the rest of the source is dropped.
    write_capacity(32'h0);
    draft = '{8'h41};
    flush_draft(1'b0);
    draft = '{8'h42};
    flush_draft(1'b1);
    wait_idle();

    // Unlimited capacity: the edges of every sequence length and each kind of
    // malformed input, ending with a source that stops mid-sequence.
    write_capacity(32'hFFFF_FFFF);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    draft = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
              8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
              8'hC0, 8'hFF, 8'h80, 8'hE2, 8'h41, 8'hE2, 8'h82};
    flush_draft(1'b1);
    // NUL mid-source, then the remainder is ignored.
    draft = '{8'h00};
    flush_draft(1'b0);
    draft = '{8'h41};
    flush_draft(1'b1);
    wait_idle();

    // One free unit: a surrogate pair cannot fit, and a replacement for a
    // broken sequence fills the output before the breaking byte is taken.
    write_capacity(32'd1);
    draft = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    flush_draft(1'b1);
    draft = '{8'hE2, 8'h41};
    flush_draft(1'b1);

    // Random phases, each with its own capacity and stall pattern. The sender
    // pauses at every phase boundary until all results are in. Some phases end
    // inside a sequence, so the next capacity applies to a half-built point.
    phase = 0;
    carry_trail = 1'b0;
    while (beats_queued < RandomBytes) begin
      wait_idle();
      case (phase % 4)
        0:       cap = $urandom_range(0, 3);
        1:       cap = $urandom_range(4, 60);
        2:       cap = 32'hFFFF_FFFF;
        default: cap = $urandom_range(61, 100000);
      endcase
      write_capacity(cap);
      tight = (cap < 4);
      case ($urandom_range(0, 2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_idle_pct = 0;
        1:       recv_idle_pct = 15;
        default: recv_idle_pct = 40;
      endcase
      start_beats = beats_queued;
      if (carry_trail) begin
        rb = {2'b10, 6'($urandom_range(0, 63))};
        draft.push_back(rb);
      end
      while (beats_queued - start_beats < 100)
        queue_source(tight ? $urandom_range(1, 6) : $urandom_range(1, 24), 1'b1);
      carry_trail = ($urandom_range(0, 2) == 0);
      if (carry_trail) begin
        rb = 8'($urandom_range(8'hE0, 8'hEF));
        draft.push_back(rb);
        rb = {2'b10, 6'($urandom_range(0, 63))};
        draft.push_back(rb);
        flush_draft(1'b0);
      end
      phase++;
    end

    // Closing stretch at full rate on both sides.
    wait_idle();
    write_capacity(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_beats = beats_queued;
    while (beats_queued - start_beats < 60) queue_source($urandom_range(1, 24), 1'b1);

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Decoded %0d source bytes over %0d random phases; %0d output beats checked.",
             bytes_decoded, phase, units_checked);
    $display("Conversions ended: %0d at end of source, %0d on NUL, %0d on full capacity.",
             stops_by_cause[u8u16_pkg::CauseEnd], stops_by_cause[u8u16_pkg::CauseNul],
             stops_by_cause[u8u16_pkg::CauseFull]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this sequence.
  initial begin
    #5_000_000;
    $display("Timeout: %0d bytes queued, %0d taken, %0d beats outstanding.",
             beats_queued, beats_taken, units_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/u8u16_pkg.sv
rtl/u8u16_step.sv
rtl/u8u16_resq.sv
rtl/utf8_to_utf16_converter.sv
test/tb_utf8_to_utf16_converter.sv
